>>> hdl/nip_pkg.sv
// ----------------------------------------------------------------------------
// nip_pkg: shared types and constants of the transform interpolator
// Beat structures, fixed-point widths and pipeline stage positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nip_pkg;

    typedef struct packed {
        logic signed [23:0] prev_pos_x;
        logic signed [23:0] prev_pos_y;
        logic signed [23:0] prev_pos_z;
        logic signed [23:0] cur_pos_x;
        logic signed [23:0] cur_pos_y;
        logic signed [23:0] cur_pos_z;
        logic [63:0]        prev_orient;
        logic [63:0]        cur_orient;
        logic [15:0]        interp_alpha;
        logic [15:0]        rate_scale;
    } t_in;

    typedef struct packed {
        logic signed [23:0] out_pos_x;
        logic signed [23:0] out_pos_y;
        logic signed [23:0] out_pos_z;
        logic signed [15:0] out_quat_w;
        logic signed [15:0] out_quat_x;
        logic signed [15:0] out_quat_y;
        logic signed [15:0] out_quat_z;
    } t_out;

    localparam int POS_W   = 24;
    localparam int B_W     = 25;   // blended component, Q.22
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 48;   // one squared component
    localparam int LSQ_W   = 50;   // squared length, Q.44
    localparam int RAD_W   = 62;   // radicand, squared length shifted by 12
    localparam int ROOT_W  = 31;
    localparam int QOUT_W  = 15;

    localparam logic [16:0]      T_ONE      = 17'd65536;
    localparam logic [LSQ_W-1:0] LEN_SQ_EPS = 50'd17592186;
    localparam logic [QOUT_W-1:0] Q14_ONE   = 15'd16384;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = 14;

    // pipeline stage positions
    localparam int ST_MUL  = 0;
    localparam int ST_T    = 1;
    localparam int ST_PROD = 2;
    localparam int ST_B    = 3;
    localparam int ST_SQ   = 4;
    localparam int ST_SUM  = 5;
    localparam int ST_ROOT = ST_SUM + 1;
    localparam int ST_NUM  = ST_ROOT + SQRT_STEPS;
    localparam int ST_OUT  = ST_NUM + DIV_STEPS + 1;
    localparam int NST     = ST_OUT + 1;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [63:0]        pq;
        logic               eq;
        logic               deg;
        logic [3:0][B_W-1:0] b;
    } t_side;

endpackage

>>> hdl/transform_nlerp_interpolator_unit.sv
// ----------------------------------------------------------------------------
// transform_nlerp_interpolator_unit: rigid transform blend
// Lerps three position components and nlerps the orientation along the
// shortest path, in a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                    payload
//   input     in          i_in_valid / o_in_ready      i_in_data  (t_in)
//   output    out         o_out_valid / i_out_ready    o_out_data (t_out)
//
// One beat is taken per cycle while the output is not stalled; the pipeline depth is
// set by the bit-per-stage square root (31 stages) and the bit-per-stage dividers
// (15 stages) of the normalisation.
// Reset is synchronous and active low; it clears only the stage valid bits.
// Each stage holds its beat while the next stage is full and stalled, so
// bubbles collapse and input beats are still taken while a result waits.
//
`timescale 1ns / 1ps

module transform_nlerp_interpolator_unit import nip_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // Stage control: a stage may load when it is empty or its beat moves on.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] vld_in;
    logic [NST:0]   en;

    assign en[NST] = i_out_ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    // Each stage takes the valid bit of the stage before it.
    assign vld_in = {r_vld[NST-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NST-1];

    // Stage 0: weight product and the four dot-product terms.
    t_in                r0_in;
    logic [31:0]        r0_prod;
    logic signed [31:0] r0_dp [4];
    logic signed [31:0] n0_dp [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n0_dp[i] = $signed(i_in_data.prev_orient[63-16*i -: 16])
                     * $signed(i_in_data.cur_orient[63-16*i -: 16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_MUL]) begin
            r0_in   <= i_in_data;
            r0_prod <= i_in_data.rate_scale * i_in_data.interp_alpha;
            r0_dp   <= n0_dp;
        end
    end

    // Stage 1: clamp the weight to one, sign of the dot product, equality.
    logic [19:0]        p_shr;
    logic [16:0]        n1_t, r1_t;
    logic signed [33:0] dot;
    t_in                r1_in;
    logic               r1_neg, r1_eq;

    assign p_shr = r0_prod[31:12];
    assign n1_t  = (p_shr > 20'(T_ONE)) ? T_ONE : p_shr[16:0];
    assign dot   = 34'(r0_dp[0]) + 34'(r0_dp[1]) + 34'(r0_dp[2]) + 34'(r0_dp[3]);

    always_ff @(posedge i_clk) begin
        if (en[ST_T]) begin
            r1_in  <= r0_in;
            r1_t   <= n1_t;
            r1_neg <= dot < 0;
            r1_eq  <= r0_in.prev_orient == r0_in.cur_orient;
        end
    end

    // Position lanes, stages two and three.
    logic signed [POS_W-1:0] lane_pos [3];

    nip_pos_lane u_pos_x (
        .i_clk (i_clk), .i_en (en[ST_B:ST_PROD]),
        .i_prev(r1_in.prev_pos_x), .i_cur(r1_in.cur_pos_x), .i_t(r1_t),
        .o_pos (lane_pos[0])
    );
    nip_pos_lane u_pos_y (
        .i_clk (i_clk), .i_en (en[ST_B:ST_PROD]),
        .i_prev(r1_in.prev_pos_y), .i_cur(r1_in.cur_pos_y), .i_t(r1_t),
        .o_pos (lane_pos[1])
    );
    nip_pos_lane u_pos_z (
        .i_clk (i_clk), .i_en (en[ST_B:ST_PROD]),
        .i_prev(r1_in.prev_pos_z), .i_cur(r1_in.cur_pos_z), .i_t(r1_t),
        .o_pos (lane_pos[2])
    );

    // Quaternion lanes, stages two to four.
    logic signed [B_W-1:0] lane_b  [4];
    logic [SQ_W-1:0]       lane_sq [4];

    for (genvar i = 0; i < 4; i++) begin : g_quat
        nip_quat_lane u_quat (
            .i_clk(i_clk),
            .i_en (en[ST_SQ:ST_PROD]),
            .i_pq ($signed(r1_in.prev_orient[63-16*i -: 16])),
            .i_cq ($signed(r1_in.cur_orient[63-16*i -: 16])),
            .i_neg(r1_neg),
            .i_t  (r1_t),
            .o_b  (lane_b[i]),
            .o_sq (lane_sq[i])
        );
    end

    // Merge: the squared length and the radicand for the square root.
    logic [LSQ_W-1:0] lsq;
    logic [RAD_W-1:0] r5_rad;

    assign lsq = LSQ_W'(lane_sq[0]) + LSQ_W'(lane_sq[1])
               + LSQ_W'(lane_sq[2]) + LSQ_W'(lane_sq[3]);

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r5_rad <= {lsq, 12'b0};
        end
    end

    // Side line: carries everything the tail needs alongside the datapath.
    t_side r_side [ST_PROD:ST_OUT-1];

    for (genvar k = ST_PROD; k < ST_OUT; k++) begin : g_side
        t_side n_side;
        always_comb begin
            if (k == ST_PROD) begin
                n_side     = '0;
                n_side.pq  = r1_in.prev_orient;
                n_side.eq  = r1_eq;
            end else begin
                n_side = r_side[k-1];
            end
            if (k == ST_SQ) begin
                n_side.pos_x = lane_pos[0];
                n_side.pos_y = lane_pos[1];
                n_side.pos_z = lane_pos[2];
            end
            if (k == ST_SUM) begin
                n_side.deg = lsq <= LEN_SQ_EPS;
                for (int i = 0; i < 4; i++) begin
                    n_side.b[i] = lane_b[i];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_side[k] <= n_side;
            end
        end
    end

    // Length of the blend.
    logic [ROOT_W-1:0] root;

    nip_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (en[ST_NUM-1:ST_ROOT]),
        .i_rad (r5_rad),
        .o_root(root)
    );

    // Divider lanes: |b| scaled by 2^20 over the length, rounded.
    logic [QOUT_W-1:0] lane_q [4];

    for (genvar i = 0; i < 4; i++) begin : g_div
        logic signed [B_W-1:0] bv;
        logic [B_W-1:0]        mag;
        assign bv  = $signed(r_side[ST_NUM-1].b[i]);
        assign mag = bv[B_W-1] ? B_W'(-bv) : B_W'(bv);

        nip_div_lane u_div (
            .i_clk(i_clk),
            .i_en (en[ST_OUT-1:ST_NUM]),
            .i_mag(mag[MAG_W-1:0]),
            .i_s  (root),
            .o_q  (lane_q[i])
        );
    end

    // Output stage: pick pass-through, zero or the signed normalised value.
    t_side             tail;
    logic [15:0]       n_quat [4];
    t_out              n_out, r_out;

    assign tail = r_side[ST_OUT-1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (tail.eq) begin
                n_quat[i] = tail.pq[63-16*i -: 16];
            end else if (tail.deg) begin
                n_quat[i] = '0;
            end else if (tail.b[i][B_W-1]) begin
                n_quat[i] = -{1'b0, lane_q[i]};
            end else begin
                n_quat[i] = {1'b0, lane_q[i]};
            end
        end
        n_out.out_pos_x  = tail.pos_x;
        n_out.out_pos_y  = tail.pos_y;
        n_out.out_pos_z  = tail.pos_z;
        n_out.out_quat_w = $signed(n_quat[0]);
        n_out.out_quat_x = $signed(n_quat[1]);
        n_out.out_quat_y = $signed(n_quat[2]);
        n_out.out_quat_z = $signed(n_quat[3]);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> hdl/nip_pos_lane.sv
// ----------------------------------------------------------------------------
// nip_pos_lane: one position component lerp
// Multiplies the difference by the weight, then rounds and adds to prev.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nip_pos_lane import nip_pkg::*; (
    input  logic                    i_clk,
    input  logic [1:0]              i_en,
    input  logic signed [POS_W-1:0] i_prev,
    input  logic signed [POS_W-1:0] i_cur,
    input  logic [16:0]             i_t,
    output logic signed [POS_W-1:0] o_pos
);

    logic signed [24:0]       diff;
    logic signed [17:0]       tsg;
    logic signed [42:0]       n_prod, r_prod;
    logic signed [POS_W-1:0]  r_prev, n_pos, r_pos;
    logic signed [42:0]       rnd;

    assign diff   = {i_cur[POS_W-1], i_cur} - {i_prev[POS_W-1], i_prev};
    assign tsg    = $signed({1'b0, i_t});
    assign n_prod = diff * tsg;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= n_prod;
            r_prev <= i_prev;
        end
    end

    assign rnd   = (r_prod + 43'sd32768) >>> 16;
    assign n_pos = r_prev + rnd[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

>>> hdl/nip_quat_lane.sv
// ----------------------------------------------------------------------------
// nip_quat_lane: one quaternion component blend
// Weighted sum of both components, rounding to Q.22, then the square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nip_quat_lane import nip_pkg::*; (
    input  logic                  i_clk,
    input  logic [2:0]            i_en,
    input  logic signed [15:0]    i_pq,
    input  logic signed [15:0]    i_cq,
    input  logic                  i_neg,
    input  logic [16:0]           i_t,
    output logic signed [B_W-1:0] o_b,
    output logic [SQ_W-1:0]       o_sq
);

    logic signed [16:0]    cqe, cqn;
    logic signed [17:0]    wp, wc;
    logic signed [35:0]    n_a, n_c, r_a, r_c, sum;
    logic signed [B_W-1:0] n_b, r_b, r_b2;
    logic signed [49:0]    n_sq;
    logic [SQ_W-1:0]       r_sq;

    assign cqe = {i_cq[15], i_cq};
    assign cqn = i_neg ? -cqe : cqe;
    assign wp  = $signed({1'b0, T_ONE - i_t});
    assign wc  = $signed({1'b0, i_t});
    assign n_a = i_pq * wp;
    assign n_c = cqn * wc;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a <= n_a;
            r_c <= n_c;
        end
    end

    assign sum = (r_a + r_c + 36'sd128) >>> 8;
    assign n_b = sum[B_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b <= n_b;
        end
    end

    assign n_sq = r_b * r_b;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sq <= n_sq[SQ_W-1:0];
            r_b2 <= r_b;
        end
    end

    assign o_b  = r_b2;
    assign o_sq = r_sq;

endmodule

>>> hdl/nip_isqrt.sv
// ----------------------------------------------------------------------------
// nip_isqrt: pipelined integer square root
// One result bit per stage, restoring compare and subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nip_isqrt import nip_pkg::*; (
    input  logic                  i_clk,
    input  logic [SQRT_STEPS-1:0] i_en,
    input  logic [RAD_W-1:0]      i_rad,
    output logic [ROOT_W-1:0]     o_root
);

    logic [63:0]       r_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0] r_root [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam int K = SQRT_STEPS - 1 - j;
        logic [63:0]       rem_in, trial, n_rem;
        logic [ROOT_W-1:0] root_in, n_root;

        if (j == 0) begin : g_first
            assign rem_in  = 64'(i_rad);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        // root has no bits at or below K yet, so the OR is an add
        assign trial = (64'(root_in) << (K + 1)) | (64'd1 << (2 * K));

        always_comb begin
            n_rem  = rem_in;
            n_root = root_in;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | (ROOT_W'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule

>>> hdl/nip_div_lane.sv
// ----------------------------------------------------------------------------
// nip_div_lane: pipelined rounded quotient of one magnitude by the length
// Saturation is decided first, then one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nip_div_lane import nip_pkg::*; (
    input  logic                 i_clk,
    input  logic [DIV_STEPS:0]   i_en,
    input  logic [MAG_W-1:0]     i_mag,
    input  logic [ROOT_W-1:0]    i_s,
    output logic [QOUT_W-1:0]    o_q
);

    localparam int NUM_W = 46;

    logic [NUM_W-1:0]     n_num;
    logic                 n_sat;
    logic [NUM_W-1:0]     r_rem [DIV_STEPS+1];
    logic [ROOT_W-1:0]    r_s   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS+1];
    logic                 r_sat [DIV_STEPS+1];

    assign n_num = NUM_W'({i_mag, 20'b0}) + NUM_W'(i_s >> 1);
    assign n_sat = n_num >= (NUM_W'(i_s) << DIV_STEPS);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= n_num;
            r_s[0]   <= i_s;
            r_q[0]   <= '0;
            r_sat[0] <= n_sat;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
        localparam int K = DIV_STEPS - j;
        logic [NUM_W-1:0]     dsub, n_rem;
        logic [DIV_STEPS-1:0] n_q;

        assign dsub = NUM_W'(r_s[j-1]) << K;

        always_comb begin
            n_rem = r_rem[j-1];
            n_q   = r_q[j-1];
            if (r_rem[j-1] >= dsub) begin
                n_rem = r_rem[j-1] - dsub;
                n_q   = r_q[j-1] | (DIV_STEPS'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem;
                r_s[j]   <= r_s[j-1];
                r_q[j]   <= n_q;
                r_sat[j] <= r_sat[j-1];
            end
        end
    end

    assign o_q = r_sat[DIV_STEPS] ? Q14_ONE : {1'b0, r_q[DIV_STEPS]};

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: transform nlerp interpolator unit
// Sends transform beats through the block under random idling on both sides
// and compares every result beat with a fixed-point prediction made here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import nip_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // Expected blends, oldest first.
    t_out blend_queue[$];
    int   fault_count = 0;
    int   cycle_count = 0;
    // When set, neither side idles; this gives the long stretch at full rate.
    bit   full_rate = 1'b0;

    transform_nlerp_interpolator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Floor division by a power of two, correct for negative values.
    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint round_shift(longint x, int s);
        return floor_shift(x + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_out predict_blend(t_in beat);
        t_out r;
        longint pp[3], cp[3], pq[4], cq[4], bl[4], rp[3], rq[4];
        longint weight, dot;
        longint unsigned lsq, root, mag, quo;
        bit same;
        pp[0] = beat.prev_pos_x; pp[1] = beat.prev_pos_y; pp[2] = beat.prev_pos_z;
        cp[0] = beat.cur_pos_x;  cp[1] = beat.cur_pos_y;  cp[2] = beat.cur_pos_z;
        same = 1'b1;
        for (int i = 0; i < 4; i++) begin
            pq[i] = longint'($signed(beat.prev_orient[63-16*i -: 16]));
            cq[i] = longint'($signed(beat.cur_orient[63-16*i -: 16]));
            if (pq[i] != cq[i]) same = 1'b0;
        end
        weight = (longint'(beat.rate_scale) * longint'(beat.interp_alpha)) >>> 12;
        if (weight > 65536) weight = 65536;
        for (int i = 0; i < 3; i++)
            rp[i] = pp[i] + round_shift((cp[i] - pp[i]) * weight, 16);
        if (same) begin
            for (int i = 0; i < 4; i++) rq[i] = pq[i];
        end else begin
            dot = 0;
            for (int i = 0; i < 4; i++) dot += pq[i] * cq[i];
            if (dot < 0)
                for (int i = 0; i < 4; i++) cq[i] = -cq[i];
            lsq = 0;
            for (int i = 0; i < 4; i++) begin
                bl[i] = round_shift(pq[i] * (65536 - weight) + cq[i] * weight, 8);
                lsq += longint'(bl[i] * bl[i]);
            end
            if (lsq <= 64'd17592186) begin
                for (int i = 0; i < 4; i++) rq[i] = 0;
            end else begin
                root = int_sqrt(lsq << 12);
                for (int i = 0; i < 4; i++) begin
                    mag = (bl[i] < 0) ? -bl[i] : bl[i];
                    quo = ((mag << 20) + (root >> 1)) / root;
                    if (quo > 16384) quo = 16384;
                    rq[i] = (bl[i] < 0) ? -longint'(quo) : longint'(quo);
                end
            end
        end
        r.out_pos_x = rp[0][23:0]; r.out_pos_y = rp[1][23:0]; r.out_pos_z = rp[2][23:0];
        r.out_quat_w = rq[0][15:0]; r.out_quat_x = rq[1][15:0];
        r.out_quat_y = rq[2][15:0]; r.out_quat_z = rq[3][15:0];
        return r;
    endfunction

    // Receiver: random stalls, and every accepted result beat is checked.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (blend_queue.size() == 0) begin
                $error("unexpected result beat %h", o_out_data);
                fault_count++;
            end else begin
                want = blend_queue.pop_front();
                if (o_out_data.out_pos_x !== want.out_pos_x) begin
                    $error("out_pos_x expected %h got %h", want.out_pos_x, o_out_data.out_pos_x);
                    fault_count++;
                end
                if (o_out_data.out_pos_y !== want.out_pos_y) begin
                    $error("out_pos_y expected %h got %h", want.out_pos_y, o_out_data.out_pos_y);
                    fault_count++;
                end
                if (o_out_data.out_pos_z !== want.out_pos_z) begin
                    $error("out_pos_z expected %h got %h", want.out_pos_z, o_out_data.out_pos_z);
                    fault_count++;
                end
                if (o_out_data.out_quat_w !== want.out_quat_w) begin
                    $error("out_quat_w expected %h got %h", want.out_quat_w, o_out_data.out_quat_w);
                    fault_count++;
                end
                if (o_out_data.out_quat_x !== want.out_quat_x) begin
                    $error("out_quat_x expected %h got %h", want.out_quat_x, o_out_data.out_quat_x);
                    fault_count++;
                end
                if (o_out_data.out_quat_y !== want.out_quat_y) begin
                    $error("out_quat_y expected %h got %h", want.out_quat_y, o_out_data.out_quat_y);
                    fault_count++;
                end
                if (o_out_data.out_quat_z !== want.out_quat_z) begin
                    $error("out_quat_z expected %h got %h", want.out_quat_z, o_out_data.out_quat_z);
                    fault_count++;
                end
            end
        end
        i_out_ready <= full_rate ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    // Sends one beat: optional idle cycles first, then valid held until taken.
    // Valid stays high after acceptance until the next call drives it again.
    // The prediction is queued at the edge of acceptance.
    task automatic send_transform(t_in beat);
        while (!full_rate && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        blend_queue.push_back(predict_blend(beat));
    endtask

    function automatic logic [63:0] rand_quat();
        return {$urandom(), $urandom()};
    endfunction

    // A unit-ish quaternion: one large component and small noise elsewhere.
    function automatic logic [63:0] rand_unit_quat();
        logic [63:0] q;
        q = '0;
        for (int i = 0; i < 4; i++)
            q[16*i +: 16] = 16'($signed($urandom_range(0, 12000)) - 6000);
        q[16*$urandom_range(0, 3) +: 16] = ($urandom_range(0, 1) ? 16'sd16000 : -16'sd16000);
        return q;
    endfunction

    function automatic t_in rand_transform();
        t_in b;
        b.prev_pos_x = 24'($urandom()); b.prev_pos_y = 24'($urandom());
        b.prev_pos_z = 24'($urandom());
        b.cur_pos_x  = 24'($urandom()); b.cur_pos_y  = 24'($urandom());
        b.cur_pos_z  = 24'($urandom());
        b.prev_orient = rand_unit_quat();
        b.cur_orient  = rand_unit_quat();
        b.interp_alpha = 16'($urandom());
        b.rate_scale   = $urandom_range(0, 4) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 4096));
        return b;
    endfunction

    task automatic test_directed();
        t_in b;
        // Position extremes at near-full weight, at zero weight and at half weight.
        b = '0;
        b.prev_pos_x = 24'h800000; b.cur_pos_x = 24'h7FFFFF;
        b.prev_pos_y = 24'h7FFFFF; b.cur_pos_y = 24'h800000;
        b.prev_pos_z = 24'h000001; b.cur_pos_z = 24'hFFFFFF;
        b.prev_orient = 64'h4000_0000_0000_0000;
        b.cur_orient  = 64'h0000_4000_0000_0000;
        b.interp_alpha = 16'hFFFF; b.rate_scale = 16'h1000;
        send_transform(b);
        b.rate_scale = 16'h0000; send_transform(b);
        b.interp_alpha = 16'h8000; b.rate_scale = 16'h1000; send_transform(b);
        // Large rate saturates the weight.
        b.interp_alpha = 16'hFFFF; b.rate_scale = 16'hFFFF; send_transform(b);
        // Equal quaternions pass through, even outside the unit range.
        b.prev_orient = 64'h8000_7FFF_8000_7FFF; b.cur_orient = b.prev_orient;
        send_transform(b);
        b.prev_orient = 64'h0000_0000_0000_0000; b.cur_orient = b.prev_orient;
        send_transform(b);
        // Negative dot product, including the most negative component.
        b.prev_orient = 64'h4000_0000_0000_0000;
        b.cur_orient  = 64'h8000_0000_0000_0001;
        b.interp_alpha = 16'h4000; b.rate_scale = 16'h1000;
        send_transform(b);
        b.cur_orient = 64'hC000_1000_0000_0000; send_transform(b);
        // Opposite quaternions are flipped onto one side; tiny components give a degenerate blend.
        b.prev_orient = 64'h4000_0000_0000_0000;
        b.cur_orient  = 64'hC000_0000_0000_0000;
        b.interp_alpha = 16'h8000; send_transform(b);
        b.prev_orient = 64'h0001_0000_0000_0000;
        b.cur_orient  = 64'h0000_0001_0000_0000;
        send_transform(b);
        // All-ones and mixed extremes.
        b.prev_orient = 64'hFFFF_FFFF_FFFF_FFFF; b.cur_orient = 64'h7FFF_7FFF_7FFF_7FFF;
        b.prev_pos_x = 24'hFFFFFF; b.cur_pos_x = 24'h000000;
        send_transform(b);
        b.prev_orient = 64'h7FFF_8000_7FFF_8000; b.cur_orient = 64'h8000_7FFF_0001_FFFF;
        b.interp_alpha = 16'h0001; b.rate_scale = 16'h0001; send_transform(b);
    endtask

    task automatic test_random(int count);
        t_in b;
        for (int n = 0; n < count; n++) begin
            b = rand_transform();
            case ($urandom_range(0, 9))
                0: b.cur_orient = b.prev_orient;
                1: begin
                    b.prev_orient = rand_quat();
                    b.cur_orient  = rand_quat();
                end
                2: b.cur_orient = {-b.prev_orient[63:48], -b.prev_orient[47:32],
                                   -b.prev_orient[31:16], -b.prev_orient[15:0]};
                default: ;
            endcase
            send_transform(b);
        end
    endtask

    task automatic test_full_rate(int count);
        full_rate = 1'b1;
        test_random(count);
        full_rate = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(900);
        test_full_rate(400);
        test_random(650);
        i_in_valid <= 1'b0;
        while (blend_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && blend_queue.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
